@@ hw/rtl/sspr_pkg.sv @@
// shared types, codes and constants for the servo status packet receiver
// no dependencies; imported by sspr_front, sspr_back and the top level

package sspr_pkg;

    // input item codes
    localparam logic [1:0] FUNC_ARM  = 2'd0;
    localparam logic [1:0] FUNC_BYTE = 2'd1;
    localparam logic [1:0] FUNC_TICK = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_TIMEOUT_MS = 2'd0;
    localparam logic [1:0] CFG_ERROR_MASK = 2'd1;
    localparam logic [1:0] CFG_MAX_ID     = 2'd2;
    localparam logic [1:0] CFG_MAX_LENGTH = 2'd3;

    // configuration reset values
    localparam logic [15:0] TIMEOUT_MS_RST = 16'd100;
    localparam logic [6:0]  ERROR_MASK_RST = 7'd127;
    localparam logic [7:0]  MAX_ID_RST     = 8'd253;
    localparam logic [7:0]  MAX_LENGTH_RST = 8'd255;

    // status codes
    localparam logic [3:0] ST_OK           = 4'd0;
    localparam logic [3:0] ST_BAD_HEADER   = 4'd1;
    localparam logic [3:0] ST_VOLTAGE      = 4'd2;
    localparam logic [3:0] ST_ANGLE        = 4'd3;
    localparam logic [3:0] ST_HEAT         = 4'd4;
    localparam logic [3:0] ST_RANGE        = 4'd5;
    localparam logic [3:0] ST_CMD_CHECKSUM = 4'd6;
    localparam logic [3:0] ST_OVERLOAD     = 4'd7;
    localparam logic [3:0] ST_INSTRUCTION  = 4'd8;
    localparam logic [3:0] ST_BAD_CHECKSUM = 4'd9;
    localparam logic [3:0] ST_TIMEOUT      = 4'd10;

    // packet framing
    localparam logic [7:0]  SYNC_BYTE   = 8'hFF;
    localparam logic [7:0]  MIN_LENGTH  = 8'd2;
    localparam logic [16:0] ELAPSED_MAX = 17'h1FFFF;

    // byte positions inside a status packet
    localparam logic [8:0] POS_SYNC0  = 9'd0;
    localparam logic [8:0] POS_SYNC1  = 9'd1;
    localparam logic [8:0] POS_ID     = 9'd2;
    localparam logic [8:0] POS_LENGTH = 9'd3;
    localparam logic [8:0] POS_ERROR  = 9'd4;
    localparam logic [8:0] POS_PARAM  = 9'd5;

    // default queue depths
    localparam int CMD_DEPTH_DEF = 4;
    localparam int RES_DEPTH_DEF = 2;

    // classified request kinds
    typedef enum logic [1:0] {
        KIND_ARM,
        KIND_BYTE,
        KIND_TICK
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
    } cmd_t;

    typedef struct packed {
        logic       end_of_packet;
        logic [7:0] payload_byte;
        logic [7:0] servo_id;
        logic [7:0] device_error;
        logic [3:0] status;
    } result_t;

    typedef struct packed {
        logic [15:0] timeout_ms;
        logic [6:0]  error_mask;
        logic [7:0]  max_id;
        logic [7:0]  max_length;
    } cfg_t;

    // first masked device error bit, lowest bit first
    function automatic logic [3:0] device_status(input logic [6:0] hits);
        logic [3:0] st;
        st = ST_OK;
        if (hits[6]) st = ST_INSTRUCTION;
        if (hits[5]) st = ST_OVERLOAD;
        if (hits[4]) st = ST_CMD_CHECKSUM;
        if (hits[3]) st = ST_RANGE;
        if (hits[2]) st = ST_HEAT;
        if (hits[1]) st = ST_ANGLE;
        if (hits[0]) st = ST_VOLTAGE;
        return st;
    endfunction

endpackage

@@ hw/rtl/sspr_fifo.sv @@
// small register-based first-in first-out queue
// generic; used between front and back and for the result queue

module sspr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage write
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count beyond depth");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (do_wr && !do_rd) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not grow on write");

    a_ptr_sync: assert property (@(posedge clk) disable iff (!rst_n)
        (empty || full) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");
`endif

endmodule

@@ hw/rtl/sspr_front.sv @@
// front end: configuration registers and request classification
// depends on sspr_pkg

module sspr_front
    import sspr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        cmd_full,
    input  logic [1:0]  func,
    input  logic [7:0]  rx_byte,
    input  logic        cfg_valid,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output logic        cfg_ready,
    output logic        cmd_push,
    output cmd_t        cmd,
    output cfg_t        cfg
);

    cfg_t cfg_reg, cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // configuration write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_TIMEOUT_MS: cfg_next.timeout_ms = cfg_data;
                CFG_ERROR_MASK: cfg_next.error_mask = cfg_data[6:0];
                CFG_MAX_ID:     cfg_next.max_id     = cfg_data[7:0];
                CFG_MAX_LENGTH: cfg_next.max_length = cfg_data[7:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_ms <= TIMEOUT_MS_RST;
            cfg_reg.error_mask <= ERROR_MASK_RST;
            cfg_reg.max_id     <= MAX_ID_RST;
            cfg_reg.max_length <= MAX_LENGTH_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // classify the request; the unused code is dropped here
    always_comb
    begin
        cmd.data = rx_byte;
        cmd.kind = KIND_ARM;
        cmd_push = 1'b0;
        case (func)
            FUNC_ARM:
            begin
                cmd.kind = KIND_ARM;
                cmd_push = push && !cmd_full;
            end
            FUNC_BYTE:
            begin
                cmd.kind = KIND_BYTE;
                cmd_push = push && !cmd_full;
            end
            FUNC_TICK:
            begin
                cmd.kind = KIND_TICK;
                cmd_push = push && !cmd_full;
            end
            default:
            begin
                cmd.kind = KIND_ARM;
                cmd_push = 1'b0;
            end
        endcase
    end

endmodule

@@ hw/rtl/sspr_back.sv @@
// back end: packet parser, timeout counter and result generation
// depends on sspr_pkg

module sspr_back
    import sspr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_empty,
    input  cmd_t    cmd,
    output logic    cmd_pop,
    input  cfg_t    cfg,
    input  logic    res_full,
    output logic    res_push,
    output result_t res
);

    logic        armed_reg,   armed_next;
    logic [8:0]  idx_reg,     idx_next;
    logic [7:0]  id_reg,      id_next;
    logic [7:0]  len_reg,     len_next;
    logic [7:0]  err_reg,     err_next;
    logic [7:0]  sum_reg,     sum_next;
    logic [16:0] elapsed_reg, elapsed_next;

    logic [16:0] elapsed_inc;
    logic [8:0]  last_param;
    logic [7:0]  sum_add;
    logic [3:0]  dev_st;

    assign cmd_pop     = !cmd_empty && !res_full;
    assign elapsed_inc = (elapsed_reg == ELAPSED_MAX) ? elapsed_reg : elapsed_reg + 1'b1;
    assign last_param  = 9'd3 + {1'b0, len_reg};
    assign sum_add     = sum_reg + cmd.data;
    assign dev_st      = device_status(err_reg[6:0] & cfg.error_mask);

    // parser update for one request
    always_comb
    begin
        armed_next   = armed_reg;
        idx_next     = idx_reg;
        id_next      = id_reg;
        len_next     = len_reg;
        err_next     = err_reg;
        sum_next     = sum_reg;
        elapsed_next = elapsed_reg;
        res_push     = 1'b0;
        res.end_of_packet = 1'b1;
        res.payload_byte  = '0;
        res.servo_id      = id_reg;
        res.device_error  = err_reg;
        res.status        = ST_OK;

        if (cmd_pop)
        begin
            case (cmd.kind)
                KIND_ARM:
                begin
                    armed_next   = 1'b1;
                    idx_next     = '0;
                    id_next      = '0;
                    len_next     = '0;
                    err_next     = '0;
                    sum_next     = '0;
                    elapsed_next = '0;
                end
                KIND_TICK:
                begin
                    if (armed_reg)
                    begin
                        elapsed_next = elapsed_inc;
                        if (elapsed_inc > {1'b0, cfg.timeout_ms})
                        begin
                            armed_next = 1'b0;
                            res_push   = 1'b1;
                            res.status = ST_TIMEOUT;
                        end
                    end
                end
                KIND_BYTE:
                begin
                    if (armed_reg)
                    begin
                        // header bytes are checked as they arrive
                        if (idx_reg == POS_SYNC0 || idx_reg == POS_SYNC1)
                        begin
                            if (cmd.data != SYNC_BYTE)
                            begin
                                armed_next = 1'b0;
                                res_push   = 1'b1;
                                res.status = ST_BAD_HEADER;
                            end
                            else
                            begin
                                idx_next = idx_reg + 1'b1;
                            end
                        end
                        else if (idx_reg == POS_ID)
                        begin
                            if (cmd.data > cfg.max_id)
                            begin
                                armed_next = 1'b0;
                                res_push   = 1'b1;
                                res.status = ST_BAD_HEADER;
                            end
                            else
                            begin
                                id_next  = cmd.data;
                                sum_next = cmd.data;
                                idx_next = POS_LENGTH;
                            end
                        end
                        else if (idx_reg == POS_LENGTH)
                        begin
                            if (cmd.data < MIN_LENGTH || cmd.data > cfg.max_length)
                            begin
                                armed_next = 1'b0;
                                res_push   = 1'b1;
                                res.status = ST_BAD_HEADER;
                            end
                            else
                            begin
                                len_next = cmd.data;
                                sum_next = sum_add;
                                idx_next = POS_ERROR;
                            end
                        end
                        else if (idx_reg == POS_ERROR)
                        begin
                            err_next = cmd.data;
                            sum_next = sum_add;
                            idx_next = POS_PARAM;
                        end
                        else if (idx_reg < last_param)
                        begin
                            // parameter byte goes straight out
                            sum_next          = sum_add;
                            idx_next          = idx_reg + 1'b1;
                            res_push          = 1'b1;
                            res.end_of_packet = 1'b0;
                            res.payload_byte  = cmd.data;
                        end
                        else
                        begin
                            // checksum byte closes the packet
                            armed_next = 1'b0;
                            res_push   = 1'b1;
                            if (dev_st != ST_OK)
                            begin
                                res.status = dev_st;
                            end
                            else if (~sum_reg != cmd.data)
                            begin
                                res.status = ST_BAD_CHECKSUM;
                            end
                            else
                            begin
                                res.status = ST_OK;
                            end
                        end
                    end
                end
                default:
                begin
                    armed_next = armed_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg   <= 1'b0;
            idx_reg     <= '0;
            id_reg      <= '0;
            len_reg     <= '0;
            err_reg     <= '0;
            sum_reg     <= '0;
            elapsed_reg <= '0;
        end
        else
        begin
            armed_reg   <= armed_next;
            idx_reg     <= idx_next;
            id_reg      <= id_next;
            len_reg     <= len_next;
            err_reg     <= err_next;
            sum_reg     <= sum_next;
            elapsed_reg <= elapsed_next;
        end
    end

`ifndef SYNTHESIS
    a_push_needs_pop: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> (cmd_pop && !res_full))
        else $error("result produced without a request");

    a_end_disarms: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res.end_of_packet) |=> !armed_reg)
        else $error("still armed after end of packet");

    a_param_in_body: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && !res.end_of_packet) |-> (armed_reg && idx_reg >= POS_PARAM))
        else $error("parameter byte outside packet body");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg > POS_PARAM) |-> (idx_reg <= last_param))
        else $error("byte position past checksum");
`endif

endmodule

@@ hw/rtl/servo_status_packet_receiver.sv @@
// top level of the servo status packet receiver
// depends on sspr_pkg, sspr_front, sspr_fifo and sspr_back

// Takes one request per clock while full is low: arm, received byte or millisecond tick.
// The front end classifies each request and queues all but the unused code
// into a command queue of CMD_DEPTH entries; the back end parses one command
// per clock while the result queue is not full, in a single registered update
// of the header checks, byte position, running checksum and timeout counter,
// and writes any result into a result queue of RES_DEPTH entries. A request
// is registered in the command queue, then its result in the result queue (empty low).
// Sustained rate is one request per clock while results are popped; full
// rises only when the result queue backs up and the command queue fills.
// Configuration writes are always taken and should be made while idle.
module servo_status_packet_receiver
    import sspr_pkg::*;
#(
    parameter int CMD_DEPTH = CMD_DEPTH_DEF,
    parameter int RES_DEPTH = RES_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  func,
    input  logic [7:0]  rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic        end_of_packet,
    output logic [7:0]  payload_byte,
    output logic [7:0]  servo_id,
    output logic [7:0]  device_error,
    output logic [3:0]  status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic    cmd_push, cmd_pop, cmd_full, cmd_empty;
    cmd_t    cmd_in, cmd_out;
    cfg_t    cfg;
    logic    res_push, res_full;
    result_t res_in, res_out;

    assign full = cmd_full;

    // request classification and configuration
    sspr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .cmd_full  (cmd_full),
        .func      (func),
        .rx_byte   (rx_byte),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_ready (cfg_ready),
        .cmd_push  (cmd_push),
        .cmd       (cmd_in),
        .cfg       (cfg)
    );

    // command queue between front and back
    sspr_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd_in),
        .rd_en   (cmd_pop),
        .rd_data (cmd_out),
        .full    (cmd_full),
        .empty   (cmd_empty)
    );

    // packet parser
    sspr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd       (cmd_out),
        .cmd_pop   (cmd_pop),
        .cfg       (cfg),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    // result queue
    sspr_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_in),
        .rd_en   (pop),
        .rd_data (res_out),
        .full    (res_full),
        .empty   (empty)
    );

    assign end_of_packet = res_out.end_of_packet;
    assign payload_byte  = res_out.payload_byte;
    assign servo_id      = res_out.servo_id;
    assign device_error  = res_out.device_error;
    assign status        = res_out.status;

endmodule

@@ verif/tb.sv @@
// testbench for servo_status_packet_receiver: random and directed status packets
// depends on sspr_pkg and the receiver RTL; self-checking against an internal packet predictor

module tb;
    import sspr_pkg::*;

    // func code that the block must ignore
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int DRAIN_CYCLES  = 16;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASES        = 8;
    localparam int RANDOM_TARGET = 1400;

    // packet predictor and expected result store
    class status_packet_scoreboard;
        // register copies
        logic [15:0] timeout_ms;
        logic [6:0]  error_mask;
        logic [7:0]  max_id;
        logic [7:0]  max_length;

        // parser state
        bit          armed;
        logic [8:0]  byte_pos;
        logic [7:0]  hdr_id;
        logic [7:0]  hdr_len;
        logic [7:0]  err_byte;
        logic [7:0]  sum;
        logic [16:0] elapsed;

        result_t     expected_q[$];
        int          failures;
        int          live_requests;
        int          params_seen;
        int          status_seen[16];

        function new();
            timeout_ms = TIMEOUT_MS_RST;
            error_mask = ERROR_MASK_RST;
            max_id     = MAX_ID_RST;
            max_length = MAX_LENGTH_RST;
            armed      = 1'b0;
            byte_pos   = '0;
            hdr_id     = '0;
            hdr_len    = '0;
            err_byte   = '0;
            sum        = '0;
            elapsed    = '0;
            failures   = 0;
            live_requests = 0;
            params_seen   = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [15:0] data);
            case (idx)
                CFG_TIMEOUT_MS: timeout_ms = data;
                CFG_ERROR_MASK: error_mask = data[6:0];
                CFG_MAX_ID:     max_id     = data[7:0];
                CFG_MAX_LENGTH: max_length = data[7:0];
                default: ;
            endcase
        endfunction

        function void close_packet(logic [3:0] st);
            result_t r;
            armed           = 1'b0;
            r.end_of_packet = 1'b1;
            r.payload_byte  = 8'd0;
            r.servo_id      = hdr_id;
            r.device_error  = err_byte;
            r.status        = st;
            expected_q.push_back(r);
        endfunction

        // lowest masked device error bit wins
        function logic [3:0] masked_error();
            logic [6:0] hits;
            hits = err_byte[6:0] & error_mask;
            for (int b = 0; b < 7; b++)
                if (hits[b]) return ST_VOLTAGE + 4'(b);
            return ST_OK;
        endfunction

        function void note_request(logic [1:0] f, logic [7:0] data);
            logic [3:0] st;
            result_t    r;
            if (f == FUNC_ARM) begin
                armed    = 1'b1;
                byte_pos = '0;
                hdr_id   = '0;
                hdr_len  = '0;
                err_byte = '0;
                sum      = '0;
                elapsed  = '0;
                live_requests++;
                return;
            end
            if (!armed || f == FUNC_UNUSED) return;
            live_requests++;

            // millisecond tick
            if (f == FUNC_TICK) begin
                if (elapsed != ELAPSED_MAX) elapsed++;
                if (elapsed > {1'b0, timeout_ms}) close_packet(ST_TIMEOUT);
                return;
            end

            // received byte
            case (byte_pos)
                POS_SYNC0, POS_SYNC1: begin
                    if (data != SYNC_BYTE) close_packet(ST_BAD_HEADER);
                    else byte_pos++;
                end
                POS_ID: begin
                    if (data > max_id) close_packet(ST_BAD_HEADER);
                    else begin
                        hdr_id   = data;
                        sum      = data;
                        byte_pos = POS_LENGTH;
                    end
                end
                POS_LENGTH: begin
                    if (data < MIN_LENGTH || data > max_length) close_packet(ST_BAD_HEADER);
                    else begin
                        hdr_len  = data;
                        sum      = sum + data;
                        byte_pos = POS_ERROR;
                    end
                end
                POS_ERROR: begin
                    err_byte = data;
                    sum      = sum + data;
                    byte_pos = POS_PARAM;
                end
                default: begin
                    if (byte_pos < {1'b0, hdr_len} + POS_LENGTH) begin
                        sum             = sum + data;
                        byte_pos++;
                        r.end_of_packet = 1'b0;
                        r.payload_byte  = data;
                        r.servo_id      = hdr_id;
                        r.device_error  = err_byte;
                        r.status        = ST_OK;
                        expected_q.push_back(r);
                    end else begin
                        st = masked_error();
                        if (st == ST_OK && ~sum != data) st = ST_BAD_CHECKSUM;
                        close_packet(st);
                    end
                end
            endcase
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
                failures++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_q.size() == 0) begin
                $error("result with nothing pending: eop %0d byte %0d status %0d",
                       got.end_of_packet, got.payload_byte, got.status);
                failures++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("end_of_packet", want.end_of_packet, got.end_of_packet);
            compare_field("payload_byte", want.payload_byte, got.payload_byte);
            compare_field("servo_id", want.servo_id, got.servo_id);
            compare_field("device_error", want.device_error, got.device_error);
            compare_field("status", want.status, got.status);
            if (want.end_of_packet) status_seen[want.status]++;
            else params_seen++;
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  func = FUNC_ARM;
    logic [7:0]  rx_byte = 8'd0;
    logic        empty;
    logic        pop = 1'b0;
    logic        end_of_packet;
    logic [7:0]  payload_byte;
    logic [7:0]  servo_id;
    logic [7:0]  device_error;
    logic [3:0]  status;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_TIMEOUT_MS;
    logic [15:0] cfg_data = 16'd0;

    status_packet_scoreboard sb;
    int cycle_count = 0;
    bit tx_eager = 1'b0;
    bit rx_eager = 1'b0;
    bit hold_request = 1'b0;

    servo_status_packet_receiver DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .func          (func),
        .rx_byte       (rx_byte),
        .empty         (empty),
        .pop           (pop),
        .end_of_packet (end_of_packet),
        .payload_byte  (payload_byte),
        .servo_id      (servo_id),
        .device_error  (device_error),
        .status        (status),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // watchdog
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("Test completed with failures");
        $finish;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99, 0);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(3, 1);
        if (r < 98) return $urandom_range(10, 4);
        return $urandom_range(50, 20);
    endfunction

    // result side: pops with random stalls and an optional long hold-off
    initial
    begin
        int stall_left;
        int hold_left;
        result_t got;
        stall_left = 0;
        hold_left  = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty) begin
                got.end_of_packet = end_of_packet;
                got.payload_byte  = payload_byte;
                got.servo_id      = servo_id;
                got.device_error  = device_error;
                got.status        = status;
                sb.check_result(got);
            end
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
                stall_left = rx_eager ? 0 : pick_gap();
            end
        end
    end

    // one request, held until taken
    task automatic send_request(input logic [1:0] f, input logic [7:0] b);
        int gap;
        push    <= 1'b1;
        func    <= f;
        rx_byte <= b;
        do @(posedge clk); while (full);
        sb.note_request(f, b);
        gap = tx_eager ? 0 : pick_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic maybe_tick(input int pct);
        if ($urandom_range(99, 0) < pct) send_request(FUNC_TICK, 8'($urandom));
    endtask

    // arm then a full status packet with random parameters
    task automatic send_packet(input logic [7:0] id, input int len, input logic [7:0] err,
                               input bit bad_sum, input int tick_pct);
        logic [7:0] total;
        logic [7:0] pb;
        send_request(FUNC_ARM, 8'($urandom));
        maybe_tick(tick_pct);
        send_request(FUNC_BYTE, SYNC_BYTE);
        send_request(FUNC_BYTE, SYNC_BYTE);
        send_request(FUNC_BYTE, id);
        maybe_tick(tick_pct);
        send_request(FUNC_BYTE, 8'(len));
        send_request(FUNC_BYTE, err);
        total = id + 8'(len) + err;
        for (int i = 0; i < len - 2; i++) begin
            maybe_tick(tick_pct);
            pb    = 8'($urandom);
            total = total + pb;
            send_request(FUNC_BYTE, pb);
        end
        maybe_tick(tick_pct);
        if (bad_sum) send_request(FUNC_BYTE, ~total ^ 8'($urandom_range(255, 1)));
        else send_request(FUNC_BYTE, ~total);
    endtask

    // one config write; valid stays high for back to back writes, apply_settings drops it after the last
    task automatic write_register(input logic [1:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.set_register(idx, data);
    endtask

    task automatic apply_settings(input logic [15:0] tmo, input logic [6:0] mask,
                                  input logic [7:0] id_max, input logic [7:0] len_max);
        write_register(CFG_TIMEOUT_MS, tmo);
        write_register(CFG_ERROR_MASK, {9'd0, mask});
        write_register(CFG_MAX_ID, {8'd0, id_max});
        write_register(CFG_MAX_LENGTH, {8'd0, len_max});
        cfg_valid <= 1'b0;
    endtask

    // let every expected result drain, then let the pipeline settle
    task automatic wait_idle();
        push <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic int pick_length();
        int hi;
        hi = sb.max_length;
        if ($urandom_range(19, 0) == 0) return $urandom_range(hi, 2);
        return $urandom_range(hi < 10 ? hi : 10, 2);
    endfunction

    function automatic logic [7:0] pick_error();
        int r;
        r = $urandom_range(9, 0);
        if (r < 5) return 8'd0;
        if (r < 8) return 8'd1 << $urandom_range(7, 0);
        return 8'($urandom);
    endfunction

    // one random packet, mostly well formed
    task automatic random_packet();
        int r;
        int len;
        int n;
        logic [7:0] id;
        r = $urandom_range(99, 0);
        if (r < 72) begin
            send_packet(8'($urandom_range(sb.max_id, 0)), pick_length(), pick_error(),
                        $urandom_range(9, 0) == 0, 5);
        end else if (r < 84) begin
            // broken header: bad id or bad length
            if ($urandom_range(1, 0)) begin
                id  = 8'($urandom_range(255, sb.max_id + 1));
                len = pick_length();
            end else begin
                id = 8'($urandom_range(sb.max_id, 0));
                if (sb.max_length < 255 && $urandom_range(1, 0))
                    len = $urandom_range(255, sb.max_length + 1);
                else
                    len = $urandom_range(1, 0);
            end
            send_packet(id, len, pick_error(), 1'b0, 0);
        end else if (r < 90) begin
            // bad sync byte
            send_request(FUNC_ARM, 8'($urandom));
            if ($urandom_range(1, 0)) send_request(FUNC_BYTE, SYNC_BYTE);
            send_request(FUNC_BYTE, 8'($urandom_range(254, 0)));
        end else if (r < 96) begin
            // partial packet then a run of ticks toward the timeout
            send_request(FUNC_ARM, 8'($urandom));
            n = $urandom_range(6, 0);
            for (int i = 0; i < n; i++) send_request(FUNC_BYTE, i < 2 ? SYNC_BYTE : 8'd1);
            n = sb.timeout_ms < 30 ? sb.timeout_ms + 2 : $urandom_range(5, 1);
            for (int i = 0; i < n; i++) send_request(FUNC_TICK, 8'($urandom));
        end else begin
            // noise
            n = $urandom_range(6, 1);
            for (int i = 0; i < n; i++) send_request(2'($urandom), 8'($urandom));
        end
    endtask

    // stimulus
    initial
    begin
        int dev_errs;
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ignored requests while not armed, unused func code
        send_request(FUNC_BYTE, SYNC_BYTE);
        send_request(FUNC_TICK, 8'h00);
        send_request(FUNC_UNUSED, 8'hA5);
        // good packet at max id with bit 7 of the error byte set
        send_packet(MAX_ID_RST, 2, 8'h80, 1'b0, 0);
        // bad first sync byte
        send_request(FUNC_ARM, 8'h00);
        send_request(FUNC_BYTE, 8'h00);
        // re-arm mid header, then id above the limit
        send_request(FUNC_ARM, 8'h00);
        send_request(FUNC_BYTE, SYNC_BYTE);
        send_request(FUNC_ARM, 8'hFF);
        send_request(FUNC_BYTE, SYNC_BYTE);
        send_request(FUNC_BYTE, SYNC_BYTE);
        send_request(FUNC_BYTE, 8'd254);
        // length below the minimum
        send_request(FUNC_ARM, 8'h00);
        send_request(FUNC_BYTE, SYNC_BYTE);
        send_request(FUNC_BYTE, SYNC_BYTE);
        send_request(FUNC_BYTE, 8'd0);
        send_request(FUNC_BYTE, 8'd1);
        wait_idle();
        // zero timeout: first tick ends the packet
        apply_settings(16'd0, 7'd0, 8'd0, MIN_LENGTH);
        send_request(FUNC_ARM, 8'h00);
        send_request(FUNC_TICK, 8'h00);
        wait_idle();

        // random phases over several register settings
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: apply_settings(TIMEOUT_MS_RST, ERROR_MASK_RST, MAX_ID_RST, MAX_LENGTH_RST);
                1: apply_settings(16'd0, 7'd0, 8'd0, MIN_LENGTH);
                2: apply_settings(16'hFFFF, ERROR_MASK_RST, MAX_ID_RST, MAX_LENGTH_RST);
                3: apply_settings(16'd5, 7'h55, 8'd20, 8'd6);
                4: apply_settings(16'd1, 7'h2A, MAX_ID_RST, MIN_LENGTH);
                default: apply_settings(16'($urandom_range(40, 0)), 7'($urandom),
                                        8'($urandom_range(253, 0)),
                                        8'($urandom_range(255, 2)));
            endcase
            tx_eager = $urandom_range(3, 0) == 0;
            rx_eager = $urandom_range(3, 0) == 0;

            // long receiver hold-off while the sender keeps pushing
            if (ph == 2) begin
                tx_eager     = 1'b1;
                hold_request = 1'b1;
                send_packet(8'd7, 60, 8'd0, 1'b0, 0);
                wait_idle();
                tx_eager = 1'b0;
            end

            while (sb.live_requests < (ph + 1) * RANDOM_TARGET / PHASES) begin
                random_packet();
                // sender pause mid phase until everything has come back
                if (ph == 5 && $urandom_range(49, 0) == 0) wait_idle();
            end
            wait_idle();
        end

        dev_errs = 0;
        for (int s = ST_VOLTAGE; s <= ST_INSTRUCTION; s++) dev_errs += sb.status_seen[s];
        $display("checked %0d parsed requests: %0d parameter bytes over %0d register settings",
                 sb.live_requests, sb.params_seen, PHASES + 2);
        $display("packet ends: ok %0d, bad header %0d, device error %0d, checksum %0d, timeout %0d",
                 sb.status_seen[ST_OK], sb.status_seen[ST_BAD_HEADER], dev_errs,
                 sb.status_seen[ST_BAD_CHECKSUM], sb.status_seen[ST_TIMEOUT]);
        if (sb.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
